// ----- hw/rtl/era_pkg.sv -----
// Package for the element-wise reduce accumulator.
// Holds the payload structs, register and status codes and the double compare helpers.
// No dependencies.
`timescale 1ns / 1ps

package era_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_REDUCE_OP     = 2'd0;
    localparam logic [1:0] CFG_DATA_TYPE     = 2'd1;
    localparam logic [1:0] CFG_ELEMENT_COUNT = 2'd2;

    // Reduction operations.
    localparam logic [2:0] OP_MAX    = 3'd0;
    localparam logic [2:0] OP_MIN    = 3'd1;
    localparam logic [2:0] OP_SUM    = 3'd2;
    localparam logic [2:0] OP_LOR    = 3'd3;
    localparam logic [2:0] OP_MINLOC = 3'd4;

    // Data types.
    localparam logic [1:0] DT_INT32  = 2'd0;
    localparam logic [1:0] DT_DOUBLE = 2'd1;
    localparam logic [1:0] DT_LOGIC  = 2'd2;
    localparam logic [1:0] DT_PAIR   = 2'd3;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_PAIR  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // Item kinds.
    localparam logic KIND_SEED = 1'b0;

    // Queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // Default quiet NaN for an invalid double addition.
    localparam logic [63:0] DBL_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

    // Work that the back carries out for one item.
    typedef enum logic [3:0] {
        ACT_ERR_PAIR,
        ACT_ERR_RANGE,
        ACT_SEED_COPY,
        ACT_SEED_ZERO,
        ACT_SEED_PAIR,
        ACT_I_MAX,
        ACT_I_MIN,
        ACT_I_SUM,
        ACT_D_MAX,
        ACT_D_MIN,
        ACT_D_SUM,
        ACT_LOR,
        ACT_MINLOC
    } era_act_t;

    typedef struct packed {
        logic        kind;
        logic [9:0]  index;
        logic [63:0] value;
        logic [63:0] location;
    } era_in_t;

    typedef struct packed {
        logic [9:0]  out_index;
        logic [63:0] out_value;
        logic [63:0] out_location;
        logic [1:0]  status;
    } era_out_t;

    // One classified item in the queue.
    typedef struct packed {
        era_act_t    act;
        logic [9:0]  index;
        logic [63:0] value;
        logic [63:0] location;
    } era_entry_t;

    // Adder request and response.
    typedef struct packed {
        logic        start;
        logic        ack;
        logic [63:0] opa;
        logic [63:0] opb;
    } era_fadd_req_t;

    typedef struct packed {
        logic        idle;
        logic        done;
        logic [63:0] result;
    } era_fadd_rsp_t;

    function automatic logic dbl_is_nan(input logic [63:0] x);
        return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
    endfunction

    // IEEE less-than: false on NaN, signed zeros compare equal.
    function automatic logic dbl_lt(input logic [63:0] a, input logic [63:0] b);
        logic r;
        if (dbl_is_nan(a) || dbl_is_nan(b))
            r = 1'b0;
        else if ((a[62:0] == 63'd0) && (b[62:0] == 63'd0))
            r = 1'b0;
        else if (a[63] != b[63])
            r = a[63];
        else if (!a[63])
            r = a[62:0] < b[62:0];
        else
            r = a[62:0] > b[62:0];
        return r;
    endfunction

    function automatic logic dbl_eq(input logic [63:0] a, input logic [63:0] b);
        logic r;
        if (dbl_is_nan(a) || dbl_is_nan(b))
            r = 1'b0;
        else
            r = (a == b) || ((a[62:0] == 63'd0) && (b[62:0] == 63'd0));
        return r;
    endfunction

endpackage

// ----- hw/rtl/era_front.sv -----
// Front of the reduce accumulator: configuration registers and item classification.
// Depends on era_pkg.
`timescale 1ns / 1ps

module era_front #(
    parameter int DEPTH = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  era_pkg::era_in_t    in_data,
    output era_pkg::era_entry_t entry
);

    logic [2:0]  reduce_op_reg;
    logic [1:0]  data_type_reg;
    logic [10:0] element_count_reg;

    // Register writes; indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reduce_op_reg     <= era_pkg::OP_MAX;
            data_type_reg     <= era_pkg::DT_INT32;
            element_count_reg <= 11'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                era_pkg::CFG_REDUCE_OP:     reduce_op_reg     <= cfg_data[2:0];
                era_pkg::CFG_DATA_TYPE:     data_type_reg     <= cfg_data[1:0];
                era_pkg::CFG_ELEMENT_COUNT: element_count_reg <= cfg_data[10:0];
                default:                    ;
            endcase
        end
    end

    logic supported;
    logic range_bad;
    logic is_int;
    logic seed;

    // Classify the arriving transfer into one action for the back.
    always_comb
    begin
        supported = 1'b0;
        case (reduce_op_reg)
            era_pkg::OP_MAX, era_pkg::OP_MIN, era_pkg::OP_SUM:
                supported = (data_type_reg == era_pkg::DT_INT32) ||
                            (data_type_reg == era_pkg::DT_DOUBLE);
            era_pkg::OP_LOR:    supported = (data_type_reg == era_pkg::DT_LOGIC);
            era_pkg::OP_MINLOC: supported = (data_type_reg == era_pkg::DT_PAIR);
            default:            supported = 1'b0;
        endcase

        range_bad = ({1'b0, in_data.index} >= element_count_reg) ||
                    (32'(in_data.index) >= DEPTH);
        is_int    = (data_type_reg == era_pkg::DT_INT32) ||
                    (data_type_reg == era_pkg::DT_LOGIC);
        seed      = (in_data.kind == era_pkg::KIND_SEED);

        entry.index    = in_data.index;
        entry.value    = is_int ? {32'd0, in_data.value[31:0]} : in_data.value;
        entry.location = in_data.location;

        if (!supported)
            entry.act = era_pkg::ACT_ERR_PAIR;
        else if (range_bad)
            entry.act = era_pkg::ACT_ERR_RANGE;
        else if (seed)
        begin
            case (reduce_op_reg)
                era_pkg::OP_SUM:    entry.act = era_pkg::ACT_SEED_ZERO;
                era_pkg::OP_MINLOC: entry.act = era_pkg::ACT_SEED_PAIR;
                default:            entry.act = era_pkg::ACT_SEED_COPY;
            endcase
        end
        else
        begin
            case (reduce_op_reg)
                era_pkg::OP_MAX:
                    entry.act = is_int ? era_pkg::ACT_I_MAX : era_pkg::ACT_D_MAX;
                era_pkg::OP_MIN:
                    entry.act = is_int ? era_pkg::ACT_I_MIN : era_pkg::ACT_D_MIN;
                era_pkg::OP_SUM:
                    entry.act = is_int ? era_pkg::ACT_I_SUM : era_pkg::ACT_D_SUM;
                era_pkg::OP_LOR:    entry.act = era_pkg::ACT_LOR;
                default:            entry.act = era_pkg::ACT_MINLOC;
            endcase
        end
    end

endmodule

// ----- hw/rtl/era_queue.sv -----
// Short queue of classified items between the front and the back.
// Depends on era_pkg.
`timescale 1ns / 1ps

module era_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  era_pkg::era_entry_t push_entry,
    input  logic                pop,
    output logic                full,
    output logic                not_empty,
    output era_pkg::era_entry_t head
);

    era_pkg::era_entry_t slots_reg [era_pkg::QDEPTH];
    logic [era_pkg::QAW-1:0] wr_ptr_reg;
    logic [era_pkg::QAW-1:0] rd_ptr_reg;
    logic [era_pkg::QAW:0]   count_reg;

    assign full      = (count_reg == (era_pkg::QAW+1)'(era_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];

    // Pointer and fill count bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Slot storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ----- hw/rtl/era_fadd.sv -----
// Multi-cycle IEEE double adder with round-to-nearest-even.
// Depends on era_pkg.
`timescale 1ns / 1ps

module era_fadd (
    input  logic                   clk,
    input  logic                   rst_n,
    input  era_pkg::era_fadd_req_t req,
    output era_pkg::era_fadd_rsp_t rsp
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ALIGN = 6'b000010,
        S_ADD   = 6'b000100,
        S_NORM  = 6'b001000,
        S_ROUND = 6'b010000,
        S_DONE  = 6'b100000
    } fadd_state_t;

    fadd_state_t state_reg, state_next;
    logic [63:0] opa_reg, opa_next;
    logic [63:0] opb_reg, opb_next;
    logic        sign_reg, sign_next;
    logic        sub_reg, sub_next;
    logic [11:0] exp_reg, exp_next;
    logic [55:0] big_reg, big_next;
    logic [55:0] small_reg, small_next;
    logic [55:0] sum_reg, sum_next;
    logic [63:0] res_reg, res_next;

    // Alignment terms.
    logic [10:0] ea, eb, ebig, esmall, shift_amt;
    logic [52:0] ma, mb, mbig, msmall;
    logic        a_nan, b_nan, a_inf, b_inf, swap;
    logic [55:0] sm_x, sm_shift, sm_mask;
    // Add and round terms.
    logic [56:0] s;
    logic [53:0] m54;
    logic [52:0] mant;
    logic [11:0] er;
    logic        round_up;

    assign rsp.idle   = (state_reg == S_IDLE);
    assign rsp.done   = (state_reg == S_DONE);
    assign rsp.result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        opa_reg   <= opa_next;
        opb_reg   <= opb_next;
        sign_reg  <= sign_next;
        sub_reg   <= sub_next;
        exp_reg   <= exp_next;
        big_reg   <= big_next;
        small_reg <= small_next;
        sum_reg   <= sum_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        opa_next   = opa_reg;
        opb_next   = opb_reg;
        sign_next  = sign_reg;
        sub_next   = sub_reg;
        exp_next   = exp_reg;
        big_next   = big_reg;
        small_next = small_reg;
        sum_next   = sum_reg;
        res_next   = res_reg;

        // Unpack both operands; a subnormal takes exponent one.
        a_nan  = era_pkg::dbl_is_nan(opa_reg);
        b_nan  = era_pkg::dbl_is_nan(opb_reg);
        a_inf  = (opa_reg[62:52] == 11'h7FF) && (opa_reg[51:0] == 52'd0);
        b_inf  = (opb_reg[62:52] == 11'h7FF) && (opb_reg[51:0] == 52'd0);
        ea     = (opa_reg[62:52] == 11'd0) ? 11'd1 : opa_reg[62:52];
        eb     = (opb_reg[62:52] == 11'd0) ? 11'd1 : opb_reg[62:52];
        ma     = {opa_reg[62:52] != 11'd0, opa_reg[51:0]};
        mb     = {opb_reg[62:52] != 11'd0, opb_reg[51:0]};
        swap   = {eb, mb} > {ea, ma};
        ebig   = swap ? eb : ea;
        esmall = swap ? ea : eb;
        mbig   = swap ? mb : ma;
        msmall = swap ? ma : mb;
        shift_amt = ebig - esmall;
        sm_x   = {msmall, 3'b000};
        if (shift_amt >= 11'd56)
        begin
            sm_mask  = '1;
            sm_shift = '0;
        end
        else
        begin
            sm_mask  = ~(56'hFF_FFFF_FFFF_FFFF << shift_amt[5:0]);
            sm_shift = sm_x >> shift_amt[5:0];
        end

        s        = sub_reg ? ({1'b0, big_reg} - {1'b0, small_reg})
                           : ({1'b0, big_reg} + {1'b0, small_reg});

        mant     = sum_reg[55:3];
        round_up = sum_reg[2] && (sum_reg[1] || sum_reg[0] || sum_reg[3]);
        m54      = {1'b0, mant} + {53'd0, round_up};
        er       = m54[53] ? (exp_reg + 12'd1) : exp_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    opa_next   = req.opa;
                    opb_next   = req.opb;
                    state_next = S_ALIGN;
                end
            end
            // Special operands finish here; others are aligned to the larger one.
            S_ALIGN:
            begin
                if (a_nan)
                begin
                    res_next   = opa_reg | 64'h0008_0000_0000_0000;
                    state_next = S_DONE;
                end
                else if (b_nan)
                begin
                    res_next   = opb_reg | 64'h0008_0000_0000_0000;
                    state_next = S_DONE;
                end
                else if (a_inf && b_inf && (opa_reg[63] != opb_reg[63]))
                begin
                    res_next   = era_pkg::DBL_DEFAULT_NAN;
                    state_next = S_DONE;
                end
                else if (a_inf)
                begin
                    res_next   = opa_reg;
                    state_next = S_DONE;
                end
                else if (b_inf)
                begin
                    res_next   = opb_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    sign_next  = swap ? opb_reg[63] : opa_reg[63];
                    sub_next   = opa_reg[63] ^ opb_reg[63];
                    exp_next   = {1'b0, ebig};
                    big_next   = {mbig, 3'b000};
                    small_next = {sm_shift[55:1],
                                  sm_shift[0] | ((sm_x & sm_mask) != 56'd0)};
                    state_next = S_ADD;
                end
            end
            // Add or subtract the aligned significands.
            S_ADD:
            begin
                if (s == 57'd0)
                begin
                    res_next   = {sub_reg ? 1'b0 : sign_reg, 63'd0};
                    state_next = S_DONE;
                end
                else if (s[56])
                begin
                    sum_next   = {s[56:2], s[1] | s[0]};
                    exp_next   = exp_reg + 12'd1;
                    state_next = S_ROUND;
                end
                else
                begin
                    sum_next   = s[55:0];
                    state_next = S_NORM;
                end
            end
            // Left normalization, a byte or a bit per cycle.
            S_NORM:
            begin
                if (sum_reg[55] || (exp_reg == 12'd1))
                    state_next = S_ROUND;
                else if ((sum_reg[55:48] == 8'd0) && (exp_reg > 12'd8))
                begin
                    sum_next = sum_reg << 8;
                    exp_next = exp_reg - 12'd8;
                end
                else
                begin
                    sum_next = sum_reg << 1;
                    exp_next = exp_reg - 12'd1;
                end
            end
            // Round to nearest even and pack.
            S_ROUND:
            begin
                if (er >= 12'd2047)
                    res_next = {sign_reg, 11'h7FF, 52'd0};
                else if (m54[53])
                    res_next = {sign_reg, er[10:0], m54[52:1]};
                else
                    res_next = {sign_reg, m54[52] ? er[10:0] : 11'd0, m54[51:0]};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (req.ack)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// ----- hw/rtl/era_back.sv -----
// Back of the reduce accumulator: accumulator store, combine stage and output register.
// Depends on era_pkg and era_fadd.
`timescale 1ns / 1ps

module era_back #(
    parameter int DEPTH = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  era_pkg::era_entry_t head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output era_pkg::era_out_t   out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [63:0] mem_val [DEPTH];
    logic [63:0] mem_loc [DEPTH];

    logic                e_valid_reg;
    era_pkg::era_entry_t e_item_reg;
    logic [63:0]         rd_val_reg;
    logic [63:0]         rd_loc_reg;

    // Last write, for the item read at the same edge.
    logic        fwd_v_reg;
    logic        fwd_l_reg;
    logic [9:0]  fwd_idx_reg;
    logic [63:0] fwd_val_reg;
    logic [63:0] fwd_loc_reg;

    logic              o_valid_reg;
    era_pkg::era_out_t o_data_reg;

    era_pkg::era_fadd_req_t fadd_req;
    era_pkg::era_fadd_rsp_t fadd_rsp;

    logic        out_free, is_dsum, e_done, adv;
    logic        wr_val_en, wr_loc_en;
    logic [63:0] acc_v, acc_l, wv, wl;
    logic [AW-1:0] rd_addr, wr_addr;
    era_pkg::era_out_t res;

    era_fadd u_fadd (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fadd_req),
        .rsp   (fadd_rsp)
    );

    assign out_free = !o_valid_reg || out_ready;
    assign is_dsum  = (e_item_reg.act == era_pkg::ACT_D_SUM);
    assign e_done   = e_valid_reg && out_free && (!is_dsum || fadd_rsp.done);
    assign adv      = head_valid && (!e_valid_reg || e_done);
    assign pop      = adv;
    assign rd_addr  = AW'(head.index);
    assign wr_addr  = AW'(e_item_reg.index);

    assign out_valid = o_valid_reg;
    assign out_data  = o_data_reg;

    assign fadd_req.start = e_valid_reg && is_dsum && fadd_rsp.idle;
    assign fadd_req.ack   = e_done && is_dsum;
    assign fadd_req.opa   = acc_v;
    assign fadd_req.opb   = e_item_reg.value;

    // Combine the entry with the item.
    always_comb
    begin
        acc_v = (fwd_v_reg && (fwd_idx_reg == e_item_reg.index)) ? fwd_val_reg : rd_val_reg;
        acc_l = (fwd_l_reg && (fwd_idx_reg == e_item_reg.index)) ? fwd_loc_reg : rd_loc_reg;
        wv        = acc_v;
        wl        = acc_l;
        wr_val_en = 1'b1;
        wr_loc_en = 1'b0;
        res.out_index    = e_item_reg.index;
        res.status       = era_pkg::STATUS_OK;

        case (e_item_reg.act)
            era_pkg::ACT_ERR_PAIR:
            begin
                wr_val_en  = 1'b0;
                res.status = era_pkg::STATUS_PAIR;
            end
            era_pkg::ACT_ERR_RANGE:
            begin
                wr_val_en  = 1'b0;
                res.status = era_pkg::STATUS_RANGE;
            end
            era_pkg::ACT_SEED_COPY: wv = e_item_reg.value;
            era_pkg::ACT_SEED_ZERO: wv = 64'd0;
            era_pkg::ACT_SEED_PAIR:
            begin
                wv        = e_item_reg.value;
                wl        = e_item_reg.location;
                wr_loc_en = 1'b1;
            end
            era_pkg::ACT_I_MAX:
                if ($signed(acc_v[31:0]) < $signed(e_item_reg.value[31:0]))
                    wv = e_item_reg.value;
            era_pkg::ACT_I_MIN:
                if ($signed(acc_v[31:0]) > $signed(e_item_reg.value[31:0]))
                    wv = e_item_reg.value;
            era_pkg::ACT_I_SUM:
                wv = {32'd0, acc_v[31:0] + e_item_reg.value[31:0]};
            era_pkg::ACT_D_MAX:
                if (era_pkg::dbl_lt(acc_v, e_item_reg.value))
                    wv = e_item_reg.value;
            era_pkg::ACT_D_MIN:
                if (era_pkg::dbl_lt(e_item_reg.value, acc_v))
                    wv = e_item_reg.value;
            era_pkg::ACT_D_SUM: wv = fadd_rsp.result;
            era_pkg::ACT_LOR:
                if (e_item_reg.value == 64'd1)
                    wv = 64'd1;
            era_pkg::ACT_MINLOC:
            begin
                wr_loc_en = 1'b1;
                if (era_pkg::dbl_lt(e_item_reg.value, acc_v))
                begin
                    wv = e_item_reg.value;
                    wl = e_item_reg.location;
                end
                else if (era_pkg::dbl_eq(e_item_reg.value, acc_v) &&
                         era_pkg::dbl_lt(e_item_reg.location, acc_l))
                    wl = e_item_reg.location;
            end
            default: wr_val_en = 1'b0;
        endcase

        res.out_value    = wr_val_en ? wv : 64'd0;
        res.out_location = wr_loc_en ? wl : 64'd0;
    end

    // Accumulator store: read on advance, write when an item completes.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_val_reg <= mem_val[rd_addr];
            rd_loc_reg <= mem_loc[rd_addr];
        end
        if (e_done && wr_val_en)
            mem_val[wr_addr] <= wv;
        if (e_done && wr_loc_en)
            mem_loc[wr_addr] <= wl;
    end

    // Stage and output control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            fwd_v_reg   <= 1'b0;
            fwd_l_reg   <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                e_valid_reg <= 1'b1;
                fwd_v_reg   <= e_done && wr_val_en;
                fwd_l_reg   <= e_done && wr_loc_en;
            end
            else if (e_done)
                e_valid_reg <= 1'b0;

            if (e_done)
                o_valid_reg <= 1'b1;
            else if (out_ready)
                o_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_item_reg  <= head;
            fwd_idx_reg <= e_item_reg.index;
            fwd_val_reg <= wv;
            fwd_loc_reg <= wl;
        end
        if (e_done)
            o_data_reg <= res;
    end

endmodule

// ----- hw/rtl/elementwise_reduce_accumulator.sv -----
// Top level of the element-wise reduce accumulator.
// Depends on era_pkg, era_front, era_queue and era_back.
//
//   Channel  Signals                            Carries
//   in       in_valid / in_ready / in_data      seed or combine item
//   out      out_valid / out_ready / out_data   entry after the step and status
//   cfg      cfg_valid / cfg_ready / cfg_*      register index and write data
//
// One item per cycle is sustained while the output is not stalled, for every operation
// except double sum, which occupies the back while the multi-cycle adder works (alignment,
// add, normalization up to a byte a cycle, rounding).
// An item passes the queue slot, the combine stage register and the output register.
// Reset clears control state only; the store is undefined until seeded.
// A four-entry queue lets the input keep accepting while the output stalls, until it is full.
`timescale 1ns / 1ps

module elementwise_reduce_accumulator #(
    parameter int DEPTH = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  era_pkg::era_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output era_pkg::era_out_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    era_pkg::era_entry_t entry;
    era_pkg::era_entry_t head;
    logic                full, not_empty, pop, push;

    assign cfg_ready = 1'b1;
    assign in_ready  = !full;
    assign push      = in_valid && !full;

    era_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .entry     (entry)
    );

    era_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (entry),
        .pop        (pop),
        .full       (full),
        .not_empty  (not_empty),
        .head       (head)
    );

    era_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (not_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
